>>> hdl/assert_macros.svh
// Assertion macros shared by the entity store RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising clock edge while reset is released.
`define ESS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("entity store assertion failed");

// A condition that must be followed by another one in the next cycle.
`define ESS_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
  `ESS_ASSERT(label, clk, rst_n, (cond) |=> (nxt))

`endif

>>> hdl/ess_pkg.sv
// Package for the entity store: sizes, operation and status codes, and the
// request, result and command types. Depends on nothing.
package ess_pkg;

  // Store size and stored position width.
  localparam int MAX_ENTRIES = 32;
  localparam int POS_WIDTH   = 32;

  // Field widths of the request and result channels.
  localparam int FUNC_W  = 3;
  localparam int ENT_W   = 5;
  localparam int SLOT_W  = 5;
  localparam int FPOS_W  = 32;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 6;

  // Internal widths derived from the store size.
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Free map search is done in groups of eight entities.
  localparam int GRP_SIZE  = 8;
  localparam int GRP_IDX_W = 3;
  localparam int NGRP      = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_W     = NGRP * GRP_SIZE;

  // Slot map value that means the entity has no component.
  localparam logic [CNT_W-1:0] SLOT_NONE = CNT_W'(MAX_ENTRIES);

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DESTROY = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ADD     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_HAS_COMP   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_COMP    = 3'd3;
  localparam logic [STAT_W-1:0] ST_SLOT_EMPTY = 3'd4;

  // One request as it enters the store.
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [ENT_W-1:0]         entity;
    logic [SLOT_W-1:0]        slot;
    logic signed [FPOS_W-1:0] pos_x;
    logic signed [FPOS_W-1:0] pos_y;
  } ess_item_t;

  // One result as it leaves the store.
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [ENT_W-1:0]         entity_out;
    logic [SLOT_W-1:0]        slot_out;
    logic signed [FPOS_W-1:0] x_out;
    logic signed [FPOS_W-1:0] y_out;
    logic [COUNT_W-1:0]       count_out;
  } ess_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } ess_cmd_t;

endpackage

>>> hdl/ess_in_if.sv
// Request channel of the entity store: valid, ready and the request fields.
// Depends on ess_pkg for the field widths.
interface ess_in_if;
  logic                                valid;
  logic                                ready;
  logic [ess_pkg::FUNC_W-1:0]          func;
  logic [ess_pkg::ENT_W-1:0]           entity;
  logic [ess_pkg::SLOT_W-1:0]          slot;
  logic signed [ess_pkg::FPOS_W-1:0]   pos_x;
  logic signed [ess_pkg::FPOS_W-1:0]   pos_y;

  modport source (output valid, func, entity, slot, pos_x, pos_y, input ready);
  modport sink (input valid, func, entity, slot, pos_x, pos_y, output ready);
endinterface

>>> hdl/ess_out_if.sv
// Result channel of the entity store: valid, ready and the result fields.
// Depends on ess_pkg for the field widths.
interface ess_out_if;
  logic                                valid;
  logic                                ready;
  logic [ess_pkg::STAT_W-1:0]          status;
  logic [ess_pkg::ENT_W-1:0]           entity_out;
  logic [ess_pkg::SLOT_W-1:0]          slot_out;
  logic signed [ess_pkg::FPOS_W-1:0]   x_out;
  logic signed [ess_pkg::FPOS_W-1:0]   y_out;
  logic [ess_pkg::COUNT_W-1:0]         count_out;

  modport source (output valid, status, entity_out, slot_out, x_out, y_out, count_out,
                  input ready);
  modport sink (input valid, status, entity_out, slot_out, x_out, y_out, count_out,
                output ready);
endinterface

>>> hdl/entity_sparse_set_store.sv
// Entity allocator with a packed position store (sparse set, swap remove).
// The request is captured on acceptance and executed once the result register is free
// or being emptied; the result is registered. No new request is accepted until the last
// has executed: the dense memory read at capture precedes the write and map update.
// Reset: all entities free, no components, count zero; no clearing pass is needed.
`include "assert_macros.svh"

module entity_sparse_set_store (
  input  logic       clk_i,
  input  logic       rst_ni,
  ess_in_if.sink     in_i,
  ess_out_if.source  out_o
);

  ess_pkg::ess_cmd_t    cmd;
  ess_pkg::ess_item_t   item;
  ess_pkg::ess_result_t result;
  logic                 in_ready;
  logic                 out_valid;

  // Gather the request fields.
  assign item.func   = in_i.func;
  assign item.entity = in_i.entity;
  assign item.slot   = in_i.slot;
  assign item.pos_x  = in_i.pos_x;
  assign item.pos_y  = in_i.pos_y;

  // Controller.
  ess_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  // Datapath.
  ess_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item),
    .result_o (result)
  );

  // Drive the channels.
  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.status     = result.status;
  assign out_o.entity_out = result.entity_out;
  assign out_o.slot_out   = result.slot_out;
  assign out_o.x_out      = result.x_out;
  assign out_o.y_out      = result.y_out;
  assign out_o.count_out  = result.count_out;

  // Sequencing checks.
  `ESS_ASSERT(a_no_accept_in_exec, clk_i, rst_ni, !(in_i.ready && cmd.exec))
  `ESS_ASSERT_NEXT(a_accept_then_busy, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  `ESS_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, cmd.exec, out_o.valid)
  `ESS_ASSERT(a_count_bound, clk_i, rst_ni, out_o.valid |-> (int'(out_o.count_out) <= ess_pkg::MAX_ENTRIES))

endmodule

>>> hdl/ess_ctrl.sv
// Controller of the entity store: capture and execute sequencing and the
// result valid flag. Depends on ess_pkg for the command type.
module ess_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output ess_pkg::ess_cmd_t cmd_o
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state, handshake and commands.
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o         = '0;
    in_ready_o    = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result register must be free or emptied in this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
    endcase
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/ess_dp.sv
// Datapath of the entity store: free map, slot map, dense storage memory,
// free entity search and the result register. Depends on ess_pkg.
module ess_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ess_pkg::ess_cmd_t    cmd_i,
  input  ess_pkg::ess_item_t   item_i,
  output ess_pkg::ess_result_t result_o
);

  localparam int IDX_W     = ess_pkg::IDX_W;
  localparam int CNT_W     = ess_pkg::CNT_W;
  localparam int POS_W     = ess_pkg::POS_WIDTH;
  localparam int MAX_E     = ess_pkg::MAX_ENTRIES;
  localparam int NGRP      = ess_pkg::NGRP;
  localparam int GRP_SIZE  = ess_pkg::GRP_SIZE;
  localparam int GRP_IDX_W = ess_pkg::GRP_IDX_W;
  localparam int PAD_W     = ess_pkg::PAD_W;

  // Control state cleared by reset.
  logic [MAX_E-1:0] free_q, free_d;
  logic [CNT_W-1:0] soe_q [MAX_E];
  logic [CNT_W-1:0] soe_d [MAX_E];
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Dense storage, undefined until written.
  logic signed [POS_W-1:0] mem_x   [MAX_E];
  logic signed [POS_W-1:0] mem_y   [MAX_E];
  logic [IDX_W-1:0]        mem_own [MAX_E];

  // Captured request and the values read at capture.
  ess_pkg::ess_item_t      item_q;
  logic [CNT_W-1:0]        soe_e_q;
  logic signed [POS_W-1:0] rd_x_q, rd_y_q;
  logic [IDX_W-1:0]        rd_own_q;
  logic [IDX_W-1:0]        rd_addr;

  // Write port.
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic signed [POS_W-1:0] wr_x, wr_y;
  logic [IDX_W-1:0]        wr_own;

  // Free entity search tree.
  logic [PAD_W-1:0]     free_pad;
  logic [NGRP-1:0]      grp_any_q, grp_any_d;
  logic [GRP_IDX_W-1:0] grp_idx_q [NGRP];
  logic [GRP_IDX_W-1:0] grp_idx_d [NGRP];
  logic                 any_free;
  logic [IDX_W-1:0]     low_idx;

  // Decoded request terms.
  logic             valid_e;
  logic             has_comp;
  logic [IDX_W-1:0] ent_idx;
  logic [IDX_W-1:0] gap;

  ess_pkg::ess_result_t res_d, result_q;

  // A read takes its own slot; everything else reads the last dense entry.
  assign rd_addr = (item_i.func == ess_pkg::FN_READ) ? IDX_W'(item_i.slot)
                                                    : IDX_W'(cnt_q - 1'b1);

  // First level of the search: lowest free entity within each group.
  assign free_pad = PAD_W'(free_q);
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (free_pad[g * GRP_SIZE + b]) begin
          grp_any_d[g] = 1'b1;
          grp_idx_d[g] = GRP_IDX_W'(b);
        end
      end
    end
  end

  // Second level: lowest group that still has a free entity.
  always_comb begin
    any_free = 1'b0;
    low_idx  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        any_free = 1'b1;
        low_idx  = IDX_W'(g * GRP_SIZE + int'(grp_idx_q[g]));
      end
    end
  end

  assign valid_e  = int'(item_q.entity) < MAX_E;
  assign has_comp = valid_e && (soe_e_q < cnt_q);
  assign ent_idx  = IDX_W'(item_q.entity);
  assign gap      = soe_e_q[IDX_W-1:0];

  // Execute step: map updates, memory write and the result.
  always_comb begin
    logic do_swap;
    do_swap  = 1'b0;
    free_d   = free_q;
    soe_d    = soe_q;
    cnt_d    = cnt_q;
    mem_we   = 1'b0;
    mem_wa   = gap;
    wr_x     = rd_x_q;
    wr_y     = rd_y_q;
    wr_own   = rd_own_q;
    res_d    = '0;
    res_d.status = ess_pkg::ST_OK;
    if (cmd_i.exec) begin
      unique case (item_q.func)
        ess_pkg::FN_CREATE: begin
          if (any_free) begin
            free_d[low_idx]  = 1'b0;
            res_d.entity_out = ess_pkg::ENT_W'(low_idx);
          end else begin
            res_d.status = ess_pkg::ST_NO_FREE;
          end
        end
        ess_pkg::FN_DESTROY: begin
          if (!valid_e) begin
            res_d.status = ess_pkg::ST_NO_COMP;
          end else begin
            if (has_comp) begin
              do_swap = 1'b1;
            end else begin
              res_d.status = ess_pkg::ST_NO_COMP;
            end
            free_d[ent_idx] = 1'b1;
          end
        end
        ess_pkg::FN_ADD: begin
          if (!valid_e) begin
            res_d.status = ess_pkg::ST_NO_COMP;
          end else if (has_comp || int'(cnt_q) >= MAX_E) begin
            res_d.status = ess_pkg::ST_HAS_COMP;
          end else begin
            mem_we           = 1'b1;
            mem_wa           = cnt_q[IDX_W-1:0];
            wr_x             = POS_W'(item_q.pos_x);
            wr_y             = POS_W'(item_q.pos_y);
            wr_own           = ent_idx;
            soe_d[ent_idx]   = cnt_q;
            res_d.slot_out   = ess_pkg::SLOT_W'(cnt_q);
            cnt_d            = cnt_q + 1'b1;
          end
        end
        ess_pkg::FN_REMOVE: begin
          if (has_comp) begin
            do_swap = 1'b1;
          end else begin
            res_d.status = ess_pkg::ST_NO_COMP;
          end
        end
        ess_pkg::FN_READ: begin
          if (int'(item_q.slot) < int'(cnt_q)) begin
            res_d.entity_out = ess_pkg::ENT_W'(rd_own_q);
            res_d.slot_out   = item_q.slot;
            res_d.x_out      = ess_pkg::FPOS_W'(rd_x_q);
            res_d.y_out      = ess_pkg::FPOS_W'(rd_y_q);
          end else begin
            res_d.status = ess_pkg::ST_SLOT_EMPTY;
          end
        end
        default: begin
        end
      endcase
      // Swap remove: the last entry moves into the gap. The removed entity's
      // mapping is cleared after the mover's, so removing the last entry works.
      if (do_swap) begin
        mem_we          = 1'b1;
        soe_d[rd_own_q] = CNT_W'(gap);
        soe_d[ent_idx]  = ess_pkg::SLOT_NONE;
        cnt_d           = cnt_q - 1'b1;
      end
      res_d.count_out = ess_pkg::COUNT_W'(cnt_d);
    end
  end

  // Maps and count, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      cnt_q  <= '0;
      for (int i = 0; i < MAX_E; i++) begin
        soe_q[i] <= ess_pkg::SLOT_NONE;
      end
    end else if (cmd_i.exec) begin
      free_q <= free_d;
      cnt_q  <= cnt_d;
      soe_q  <= soe_d;
    end
  end

  // Dense storage memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[mem_wa]   <= wr_x;
      mem_y[mem_wa]   <= wr_y;
      mem_own[mem_wa] <= wr_own;
    end
    if (cmd_i.capture) begin
      rd_x_q   <= mem_x[rd_addr];
      rd_y_q   <= mem_y[rd_addr];
      rd_own_q <= mem_own[rd_addr];
    end
  end

  // Request capture, search tree leaves and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= item_i;
      soe_e_q <= soe_q[IDX_W'(item_i.entity)];
    end
    grp_any_q <= grp_any_d;
    grp_idx_q <= grp_idx_d;
    if (cmd_i.exec) begin
      result_q <= res_d;
    end
  end

  assign result_o = result_q;

endmodule
